// ----- hdl/fac_pkg.sv -----
// Shared constants for the frustum box culling block.
`default_nettype none
package fac_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int EXT_WIDTH   = COORD_WIDTH - 1;
    localparam int PL_W        = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * PL_W;
    localparam int ACC_W       = PROD_W + 4;
    localparam int ROW_LSB     = 2;
    localparam int CEN_LSB     = ROW_LSB + 4 * COORD_WIDTH;
    localparam int EXT_LSB     = CEN_LSB + 3 * COORD_WIDTH;
    localparam int IN_BITS     = EXT_LSB + 3 * EXT_WIDTH;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W       = 8;
    localparam int NUM_PLANES  = 6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BOX  = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/frustum_aabb_cull.sv -----
// Frustum culling of axis-aligned boxes against planes from a stored clip matrix.
// Load item: writes one matrix row, no result.
// Box item: PLANE, MUL and ACC states per plane on one shared 33x33 multiplier, 6 planes;
//   it stops at the first plane that culls. Result and ready return together when the box ends.
// Result waits in an output register; a box finishing while it is still held stalls.
// Reset clears control state only; matrix rows are undefined until loaded.
`default_nettype none
module frustum_aabb_cull
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // row_index, row_x, row_y, row_z, row_w, centre_x, centre_y, centre_z,
    // extent_x, extent_y, extent_z, zero pad
    input  wire logic [fac_pkg::IN_W-1:0]      s_axis_tdata,
    // cmd
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // visible, zero pad
    output logic [fac_pkg::OUT_W-1:0]          m_axis_tdata
);
    import fac_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PLANE, S_MUL, S_ACC} state_t;

    state_t state_reg, state_next;
    logic [2:0] plane_reg, plane_next;
    logic [1:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    logic       vis_reg, vis_next;

    logic signed [COORD_WIDTH-1:0] rows_reg [4][4];
    logic signed [COORD_WIDTH-1:0] centre_reg [3];
    logic [EXT_WIDTH-1:0]          extent_reg [3];
    logic signed [PL_W-1:0]        pl_reg [4];
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic signed [PL_W-1:0]   pl_comb [4];
    logic signed [PL_W-1:0]   r3_x, rs_x;
    logic [1:0]               sel_row;
    logic signed [PL_W-1:0]   pl_sel, c_ext, e_ext, opnd;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_sum;
    logic                     in_fire, slot_free;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign slot_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        case (plane_reg)
            3'd0, 3'd1: sel_row = 2'd0;
            3'd2, 3'd3: sel_row = 2'd1;
            default:    sel_row = 2'd2;
        endcase
    end

    always_comb
    begin
        r3_x = '0;
        rs_x = '0;
        for (int k = 0; k < 4; k++)
        begin
            r3_x = PL_W'(rows_reg[3][k]);
            rs_x = PL_W'(rows_reg[sel_row][k]);
            case (plane_reg)
                3'd0, 3'd2: pl_comb[k] = r3_x + rs_x;
                3'd4:       pl_comb[k] = rs_x;
                default:    pl_comb[k] = r3_x - rs_x;
            endcase
        end
    end

    // n*c + |n|*e == n*(c + e) for n >= 0, n*(c - e) for n < 0
    assign pl_sel  = pl_reg[k_reg];
    assign c_ext   = PL_W'(centre_reg[k_reg]);
    assign e_ext   = signed'(PL_W'(extent_reg[k_reg]));
    assign opnd    = pl_sel[PL_W-1] ? (c_ext - e_ext) : (c_ext + e_ext);
    assign prod    = pl_sel * opnd;
    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        state_next   = state_reg;
        plane_next   = plane_reg;
        k_next       = k_reg;
        vis_next     = vis_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && s_axis_tuser[0] == CMD_BOX)
                begin
                    plane_next = '0;
                    state_next = S_PLANE;
                end
            end
            S_PLANE:
            begin
                k_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_sum[ACC_W-1] || plane_reg == 3'(NUM_PLANES - 1))
                begin
                    if (slot_free)
                    begin
                        vis_next     = !acc_sum[ACC_W-1];
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    plane_next = plane_reg + 3'd1;
                    state_next = S_PLANE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            plane_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            vis_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            plane_reg   <= plane_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            vis_reg     <= vis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (s_axis_tuser[0] == CMD_LOAD)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    rows_reg[s_axis_tdata[ROW_LSB-1:0]][k] <=
                        s_axis_tdata[ROW_LSB + k*COORD_WIDTH +: COORD_WIDTH];
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    centre_reg[k] <= s_axis_tdata[CEN_LSB + k*COORD_WIDTH +: COORD_WIDTH];
                    extent_reg[k] <= s_axis_tdata[EXT_LSB + k*EXT_WIDTH +: EXT_WIDTH];
                end
            end
        end
        case (state_reg)
            S_PLANE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    pl_reg[k] <= pl_comb[k];
                end
                acc_reg <= ACC_W'(pl_comb[3]) <<< FRAC_BITS;
            end
            S_MUL:
            begin
                prod_reg <= prod;
                if (k_reg != 2'd0)
                begin
                    acc_reg <= acc_sum;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, vis_reg};

    a_box_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_BOX) |=> !s_axis_tready)
        else $error("ready high right after box accept");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_LOAD && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("result produced by a load item");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLANE || state_reg == S_ACC) |-> plane_reg < 3'(NUM_PLANES))
        else $error("plane counter out of range");
endmodule
`default_nettype wire
